// File: hdl/npg_pkg.sv
// ----------------------------------------------------------------------------
// npg_pkg: shared types and constants of the next permutation generator
// Field widths of the stream and configuration ports, and the control
// group that the sequencer drives into the permutation store.
// ----------------------------------------------------------------------------
package npg_pkg;

	localparam int CFG_W  = 5;
	localparam int VAL_W  = 5;
	localparam int POS_W  = 4;
	localparam int ODATA_W = 16;
	localparam int OUSER_W = 2;
	localparam int IDATA_W = 8;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic wr_en;
	} mem_ctrl_t;

endpackage

// File: hdl/npg_perm_mem.sv
// ----------------------------------------------------------------------------
// npg_perm_mem: permutation store
// One write port and two registered read ports. Each entry has a valid bit;
// an entry that is not valid reads as its identity value, address plus one.
// ----------------------------------------------------------------------------
module npg_perm_mem
	import npg_pkg::*;
#(
	parameter int MAX_LEN = 16,
	parameter int AW = 4,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_ctrl_t     ctrl,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	input  logic [AW-1:0] waddr,
	input  logic [VW-1:0] wdata,
	output logic [VW-1:0] rdata_a,
	output logic [VW-1:0] rdata_b
);

	logic [VW-1:0]      mem_q [MAX_LEN];
	logic [MAX_LEN-1:0] vld_q;

	// Clearing the valid bits restores the identity permutation at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.clear) begin
			vld_q <= '0;
		end else if (ctrl.wr_en) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rdata_a <= vld_q[raddr_a] ? mem_q[raddr_a] : VW'(raddr_a) + VW'(1);
			rdata_b <= vld_q[raddr_b] ? mem_q[raddr_b] : VW'(raddr_b) + VW'(1);
		end
	end

endmodule

// File: hdl/npg_ctrl.sv
// ----------------------------------------------------------------------------
// npg_ctrl: sequencer of the permutation generator
// Scans for the pivot, emits the permutation one beat per element, then
// swaps and reverses the tail in the store, all through one comparator.
// ----------------------------------------------------------------------------
module npg_ctrl
	import npg_pkg::*;
#(
	parameter int AW = 4,
	parameter int VW = 5,
	parameter int LW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             restart,
	input  logic [LW-1:0]    n_eff,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] out_value,
	output logic [POS_W-1:0] out_pos,
	output logic             out_last,
	output logic             out_final,
	output logic             out_exh,
	output mem_ctrl_t        mem_ctrl,
	output logic [AW-1:0]    raddr_a,
	output logic [AW-1:0]    raddr_b,
	output logic [AW-1:0]    waddr,
	output logic [VW-1:0]    wdata,
	input  logic [VW-1:0]    rdata_a,
	input  logic [VW-1:0]    rdata_b
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SCAN_RD  = 12'b0000_0000_0010,
		S_SCAN_CMP = 12'b0000_0000_0100,
		S_EMIT_RD  = 12'b0000_0000_1000,
		S_EMIT_OUT = 12'b0000_0001_0000,
		S_FIND_RD  = 12'b0000_0010_0000,
		S_FIND_CMP = 12'b0000_0100_0000,
		S_SWAP_W   = 12'b0000_1000_0000,
		S_REV_RD   = 12'b0001_0000_0000,
		S_REV_W1   = 12'b0010_0000_0000,
		S_REV_W2   = 12'b0100_0000_0000,
		S_EXH      = 12'b1000_0000_0000
	} state_t;

	state_t        state_q;
	logic          done_q;
	logic          found_q;
	logic [LW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic [AW-1:0] piv_q;
	logic [VW-1:0] pval_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;
	logic             out_final_q;
	logic             out_exh_q;

	logic          accept;
	logic          slot_free;
	logic          ld;
	logic          k_last;
	logic [VW-1:0] cmp_a;
	logic [VW-1:0] cmp_b;
	logic          cmp_lt;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign ld        = slot_free && ((state_q == S_EMIT_OUT) || (state_q == S_EXH));
	assign k_last    = (k_q == AW'(n_q - LW'(1)));

	// The one comparator, shared by the pivot scan, the successor search and
	// the end test of the tail reversal.
	always_comb begin
		unique case (state_q)
			S_SCAN_CMP: begin
				cmp_a = rdata_a;
				cmp_b = rdata_b;
			end
			S_FIND_CMP: begin
				cmp_a = pval_q;
				cmp_b = rdata_a;
			end
			default: begin
				cmp_a = VW'(lo_q);
				cmp_b = VW'(hi_q);
			end
		endcase
	end
	assign cmp_lt = (cmp_a < cmp_b);

	always_comb begin
		mem_ctrl       = '0;
		raddr_a        = lo_q;
		raddr_b        = hi_q;
		waddr          = lo_q;
		wdata          = rdata_b;
		mem_ctrl.clear = accept && restart;
		unique case (state_q)
			S_SCAN_RD: begin
				mem_ctrl.rd_en = 1'b1;
				raddr_a        = i_q;
				raddr_b        = AW'(i_q + 1'b1);
			end
			S_EMIT_RD: begin
				mem_ctrl.rd_en = 1'b1;
				raddr_a        = k_q;
			end
			S_FIND_RD: begin
				mem_ctrl.rd_en = 1'b1;
				raddr_a        = j_q;
			end
			S_FIND_CMP: begin
				mem_ctrl.wr_en = cmp_lt;
				waddr          = piv_q;
				wdata          = rdata_a;
			end
			S_SWAP_W: begin
				mem_ctrl.wr_en = 1'b1;
				waddr          = j_q;
				wdata          = pval_q;
			end
			S_REV_RD: begin
				mem_ctrl.rd_en = cmp_lt;
			end
			S_REV_W1: begin
				mem_ctrl.wr_en = 1'b1;
				waddr          = lo_q;
				wdata          = rdata_b;
			end
			S_REV_W2: begin
				mem_ctrl.wr_en = 1'b1;
				waddr          = hi_q;
				wdata          = rdata_a;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			n_q     <= LW'(1);
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			piv_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= n_eff;
						k_q     <= '0;
						found_q <= 1'b0;
						if (restart) begin
							done_q <= 1'b0;
						end
						if (done_q && !restart) begin
							state_q <= S_EXH;
						end else if (n_eff == LW'(1)) begin
							state_q <= S_EMIT_RD;
						end else begin
							i_q     <= AW'(n_eff - LW'(2));
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (cmp_lt) begin
						found_q <= 1'b1;
						piv_q   <= i_q;
						state_q <= S_EMIT_RD;
					end else if (i_q == '0) begin
						state_q <= S_EMIT_RD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (slot_free) begin
						if (!k_last) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EMIT_RD;
						end else if (found_q) begin
							j_q     <= AW'(n_q - LW'(1));
							state_q <= S_FIND_RD;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CMP;
				end
				S_FIND_CMP: begin
					if (cmp_lt) begin
						state_q <= S_SWAP_W;
					end else begin
						j_q     <= j_q - 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_SWAP_W: begin
					lo_q    <= AW'(piv_q + 1'b1);
					hi_q    <= AW'(n_q - LW'(1));
					state_q <= S_REV_RD;
				end
				S_REV_RD: begin
					state_q <= cmp_lt ? S_REV_W1 : S_IDLE;
				end
				S_REV_W1: begin
					state_q <= S_REV_W2;
				end
				S_REV_W2: begin
					lo_q    <= lo_q + 1'b1;
					hi_q    <= hi_q - 1'b1;
					state_q <= S_REV_RD;
				end
				S_EXH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The pivot value is caught while the scan compares, ready for the swap.
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN_CMP) && cmp_lt) begin
			pval_q <= rdata_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			if (state_q == S_EXH) begin
				out_value_q <= '0;
				out_pos_q   <= '0;
				out_last_q  <= 1'b1;
				out_final_q <= 1'b0;
				out_exh_q   <= 1'b1;
			end else begin
				out_value_q <= VAL_W'(rdata_a);
				out_pos_q   <= POS_W'(k_q);
				out_last_q  <= k_last;
				out_final_q <= !found_q;
				out_exh_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid  = out_valid_q;
	assign out_value = out_value_q;
	assign out_pos   = out_pos_q;
	assign out_last  = out_last_q;
	assign out_final = out_final_q;
	assign out_exh   = out_exh_q;

	// The store never sees a write together with a clear or a read.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctrl.wr_en && (mem_ctrl.clear || mem_ctrl.rd_en)))
		else $error("npg_ctrl: store write collides with clear or read");

	// Loading the last beat of the final permutation marks the run exhausted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ld && (state_q == S_EMIT_OUT) && k_last && !found_q) |=> done_q)
		else $error("npg_ctrl: final permutation did not set exhausted");

	// An exhausted beat always closes its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_exh_q) |-> (out_last_q && !out_final_q))
		else $error("npg_ctrl: exhausted beat without last mark");

	// A request that finds the store exhausted goes straight to the exhausted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done_q && !restart) |=> (state_q == S_EXH))
		else $error("npg_ctrl: exhausted request did not take the exhausted path");

endmodule

// File: hdl/next_permutation_generator_unit.sv
// Flow: one request at a time, taken only while idle. The block scans up to n-1 pivot
// candidates, then reads and loads the beats one by one, each held while the output stalls.
// After the last beat it runs the successor search (at most n-1 steps), one swap write,
// the reversed pairs of the tail (a read and two writes each) and one closing check,
// then returns to idle before it takes the next request.
// An exhausted request yields a single exhausted beat. Reset: store reads as identity, length is 4.
// ----------------------------------------------------------------------------
// next_permutation_generator_unit: lexicographic permutation generator
// Emits the current permutation of 1..n as one beat per element, then
// advances it in place to its lexicographic successor, if it has one.
// ----------------------------------------------------------------------------
module next_permutation_generator_unit
	import npg_pkg::*;
#(
	parameter int MAX_LEN = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,   // [4:0] element_value, [8:5] element_position
	output logic               m_tlast,
	output logic [OUSER_W-1:0] m_tuser,   // [0] final_permutation, [1] exhausted
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int VW = $clog2(MAX_LEN + 1);
	localparam int LW = $clog2(MAX_LEN + 1);

	logic [CFG_W-1:0] len_q;
	logic [LW-1:0]    n_eff;

	mem_ctrl_t        mem_ctrl;
	logic [AW-1:0]    raddr_a;
	logic [AW-1:0]    raddr_b;
	logic [AW-1:0]    waddr;
	logic [VW-1:0]    wdata;
	logic [VW-1:0]    rdata_a;
	logic [VW-1:0]    rdata_b;

	logic [VAL_W-1:0] out_value;
	logic [POS_W-1:0] out_pos;
	logic             out_final;
	logic             out_exh;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= CFG_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	// A length of zero runs as one, a length beyond the store saturates.
	always_comb begin
		if (len_q == '0) begin
			n_eff = LW'(1);
		end else if (int'(len_q) > MAX_LEN) begin
			n_eff = LW'(MAX_LEN);
		end else begin
			n_eff = LW'(len_q);
		end
	end

	npg_ctrl #(
		.AW      (AW),
		.VW      (VW),
		.LW      (LW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.restart   (s_tdata[0]),
		.n_eff     (n_eff),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_value (out_value),
		.out_pos   (out_pos),
		.out_last  (m_tlast),
		.out_final (out_final),
		.out_exh   (out_exh),
		.mem_ctrl  (mem_ctrl),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.waddr     (waddr),
		.wdata     (wdata),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b)
	);

	npg_perm_mem #(
		.MAX_LEN (MAX_LEN),
		.AW      (AW),
		.VW      (VW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.waddr   (waddr),
		.wdata   (wdata),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign m_tdata = {{(ODATA_W - VAL_W - POS_W){1'b0}}, out_pos, out_value};
	assign m_tuser = {out_exh, out_final};

endmodule

// File: tb/sv/next_permutation_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_permutation_generator_unit_test: self-checking bench of the generator
// Drives restart/continue requests under random stream gaps and back-pressure.
// The length register is rewritten between phases, its extremes included.
// Each emitted element is checked against a lexicographic successor tracker.
// ----------------------------------------------------------------------------
module next_permutation_generator_unit_test
	import npg_pkg::*;
;

	localparam int MAX_LEN     = 16;
	localparam int CLK_PERIOD  = 4;
	localparam int SETTLE_WAIT = 160;  // covers the successor search at full length
	localparam int TARGET_REQS = 170;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		logic             last;
		logic             final_perm;
		logic             exhausted;
	} perm_element_t;

	class permutation_tracker;
		logic [VAL_W-1:0] arrangement [MAX_LEN];
		logic [CFG_W-1:0] length_reg;
		bit               all_emitted;
		perm_element_t    pending_elements [$];
		int               errors;

		function new();
			reload_identity();
			all_emitted = 1'b0;
			length_reg  = 5'd4;
			errors      = 0;
		endfunction

		function void reload_identity();
			for (int k = 0; k < MAX_LEN; k++)
				arrangement[k] = VAL_W'(k + 1);
		endfunction

		function void set_length(logic [CFG_W-1:0] value);
			length_reg = value;
		endfunction

		function int pending();
			return pending_elements.size();
		endfunction

		// One request: emit the current arrangement, then step to its successor.
		function void note_request(bit restart);
			logic [VAL_W-1:0] shown [MAX_LEN];
			logic [VAL_W-1:0] t;
			perm_element_t    e;
			int               n;
			int               pivot;
			int               swap_at;
			int               lo;
			int               hi;
			bit               was_last;

			if (restart) begin
				reload_identity();
				all_emitted = 1'b0;
			end
			if (all_emitted) begin
				e = '{value: '0, position: '0, last: 1'b1,
					final_perm: 1'b0, exhausted: 1'b1};
				pending_elements.push_back(e);
				return;
			end
			n = (length_reg == 0) ? 1 : ((length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg));
			for (int k = 0; k < n; k++)
				shown[k] = arrangement[k];

			pivot = n - 2;
			while (pivot >= 0) begin
				if (arrangement[pivot] < arrangement[pivot + 1])
					break;
				pivot--;
			end
			was_last = (pivot < 0);
			if (was_last) begin
				all_emitted = 1'b1;
			end else begin
				swap_at = n - 1;
				while (arrangement[swap_at] <= arrangement[pivot])
					swap_at--;
				t = arrangement[pivot];
				arrangement[pivot] = arrangement[swap_at];
				arrangement[swap_at] = t;
				lo = pivot + 1;
				hi = n - 1;
				while (lo < hi) begin
					t = arrangement[lo];
					arrangement[lo] = arrangement[hi];
					arrangement[hi] = t;
					lo++;
					hi--;
				end
			end

			for (int k = 0; k < n; k++) begin
				e.value      = shown[k];
				e.position   = POS_W'(k);
				e.last       = (k == n - 1);
				e.final_perm = was_last;
				e.exhausted  = 1'b0;
				pending_elements.push_back(e);
			end
		endfunction

		function void check_element(perm_element_t got);
			perm_element_t want;

			if (pending_elements.size() == 0) begin
				$display({"%0t: beat with nothing expected: value %0d position %0d",
					" last %0b final %0b exhausted %0b"},
					$time, got.value, got.position, got.last, got.final_perm,
					got.exhausted);
				errors++;
				return;
			end
			want = pending_elements.pop_front();
			if (got.value !== want.value) begin
				$display("%0t: element_value expected %0d, got %0d",
					$time, want.value, got.value);
				errors++;
			end
			if (got.position !== want.position) begin
				$display("%0t: element_position expected %0d, got %0d",
					$time, want.position, got.position);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_element expected %0b, got %0b",
					$time, want.last, got.last);
				errors++;
			end
			if (got.final_perm !== want.final_perm) begin
				$display("%0t: final_permutation expected %0b, got %0b",
					$time, want.final_perm, got.final_perm);
				errors++;
			end
			if (got.exhausted !== want.exhausted) begin
				$display("%0t: exhausted expected %0b, got %0b",
					$time, want.exhausted, got.exhausted);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IDATA_W-1:0] s_tdata;    // [0] restart, [7:1] zero
	logic               m_tvalid;
	logic               m_tready;
	logic [ODATA_W-1:0] m_tdata;    // [4:0] element_value, [8:5] element_position
	logic               m_tlast;
	logic [OUSER_W-1:0] m_tuser;    // [0] final_permutation, [1] exhausted
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;

	permutation_tracker tracker;
	int                 requests_sent = 0;
	int                 sink_hold = 0;
	bit                 sink_steady = 1'b0;
	bit                 src_steady = 1'b0;

	next_permutation_generator_unit #(
		.MAX_LEN(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_request(input bit restart);
		int gap;

		gap = src_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {{(IDATA_W - 1){1'b0}}, restart};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.note_request(restart);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain_source();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (tracker.pending() != 0);
	endtask

	// The block is idle only after its last beat and the successor search behind it.
	task automatic start_phase(input logic [CFG_W-1:0] length_value);
		drain_source();
		repeat (SETTLE_WAIT) @(negedge clk);
		cfg_data  <= length_value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.set_length(length_value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int            gap;
		perm_element_t got;

		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end
			gap = sink_steady ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.value      = m_tdata[VAL_W-1:0];
			got.position   = m_tdata[VAL_W+POS_W-1:VAL_W];
			got.last       = m_tlast;
			got.final_perm = m_tuser[0];
			got.exhausted  = m_tuser[1];
			tracker.check_element(got);
		end
	end

	initial begin : watchdog
		#(2_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int               pick;
		int               count;
		logic [CFG_W-1:0] length_value;

		tracker   = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset length of four, starting from the reset arrangement.
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);

		// A single element is its own last permutation.
		start_phase(5'd1);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);

		// Zero length behaves as one.
		start_phase(5'd0);
		send_request(1'b1);
		send_request(1'b0);

		start_phase(5'd2);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);

		// Largest register value saturates to the full store.
		start_phase(5'd31);
		send_request(1'b1);
		send_request(1'b0);

		// Run all six orderings of three, then one more request past the end.
		start_phase(5'd3);
		send_request(1'b1);
		repeat (6) send_request(1'b0);

		// A new length does not clear the exhausted state; only restart does.
		start_phase(5'd5);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);

		// Sink stalls for a long stretch while the source keeps pushing.
		start_phase(5'd4);
		src_steady = 1'b1;
		sink_hold  = 300;
		send_request(1'b1);
		repeat (5) send_request(1'b0);
		src_steady = 1'b0;

		while (requests_sent < TARGET_REQS) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				length_value = CFG_W'($urandom_range(2, 5));
			else if (pick < 16)
				length_value = CFG_W'($urandom_range(6, 8));
			else if (pick == 16)
				length_value = 5'd16;
			else if (pick == 17)
				length_value = CFG_W'($urandom_range(17, 31));
			else if (pick == 18)
				length_value = CFG_W'($urandom_range(0, 1));
			else
				length_value = CFG_W'($urandom_range(9, 15));
			start_phase(length_value);
			src_steady  = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			count = (length_value > 8) ? $urandom_range(2, 4) : $urandom_range(4, 16);
			for (int k = 0; k < count; k++) begin
				if ($urandom_range(0, 9) == 0)
					drain_source();
				if (k == 0)
					send_request($urandom_range(0, 1));
				else
					send_request($urandom_range(0, 9) == 0);
			end
		end

		drain_source();
		repeat (SETTLE_WAIT) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
